[rtl/core/rttc_pkg.sv]
package rttc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 32;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegAutoOffEnable  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegAutoOffSeconds = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegMotionEnable   = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegMotionSeconds  = 2'd3;

  typedef struct packed {
    logic                 auto_off_enable;
    logic [TimeWidth-1:0] auto_off_seconds;
    logic                 motion_enable;
    logic [TimeWidth-1:0] motion_seconds;
  } rttc_cfg_t;

  typedef struct packed {
    logic                 toggle_level;
    logic                 clear_level;
    logic                 motion_level;
    logic                 panic_level;
    logic [TimeWidth-1:0] now_sec;
    logic                 initial_output;
    logic                 remote_valid;
    logic                 remote_value;
  } rttc_item_t;

  typedef struct packed {
    logic                 relay_state;
    logic                 reported_state;
    logic                 first_pending;
    logic                 toggle_prev;
    logic                 clear_prev;
    logic                 motion_prev;
    logic                 panic_prev;
    logic                 motion_running;
    logic [TimeWidth-1:0] auto_off_start;
    logic [TimeWidth-1:0] motion_start;
  } rttc_state_t;

  typedef struct packed {
    logic relay_on;
    logic report_written;
  } rttc_result_t;

endpackage

[rtl/core/relay_toggle_timer_controller.sv]
// Relay toggle timer controller.
// Input channel (in_valid / in_stall): one poll transaction carries the
// toggle, clear, motion and panic levels, the time in seconds, the hardware
// readback for the first poll and an optional remote write.
// Output channel (out_valid / out_stall): one transaction per poll with the
// relay state and a flag that the state was published this poll.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 auto-off
// enable, 1 auto-off seconds, 2 motion enable, 3 motion seconds); write
// only while no poll is in flight.
// A poll waits in the input register until its result is registered.
// Throughput: one poll per cycle while out_stall does not hold the result;
// the whole poll step (edge detects, two 32-bit subtract-and-compare timers,
// a few muxes) sits between the input register and the result register, and
// the state updates with the result.
// Reset clears the configuration and relay state; the next poll is treated
// as the first. When the receiver stalls, the result holds, one further poll
// is taken into the input register, and then in_stall rises.
module relay_toggle_timer_controller
  import rttc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     toggle_level,
  input  logic                     clear_level,
  input  logic                     motion_level,
  input  logic                     panic_level,
  input  logic [TimeWidth-1:0]     now_sec,
  input  logic                     initial_output,
  input  logic                     remote_valid,
  input  logic                     remote_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     relay_on,
  output logic                     report_written,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  rttc_cfg_t    cfg;
  rttc_item_t   item;
  logic         item_valid;
  rttc_state_t  state;
  rttc_state_t  state_next;
  rttc_result_t result_next;
  logic         advance;
  logic         in_take;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegAutoOffEnable:  cfg.auto_off_enable  <= cfg_data[0];
        RegAutoOffSeconds: cfg.auto_off_seconds <= cfg_data[TimeWidth-1:0];
        RegMotionEnable:   cfg.motion_enable    <= cfg_data[0];
        RegMotionSeconds:  cfg.motion_seconds   <= cfg_data[TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.toggle_level   <= toggle_level;
      item.clear_level    <= clear_level;
      item.motion_level   <= motion_level;
      item.panic_level    <= panic_level;
      item.now_sec        <= now_sec;
      item.initial_output <= initial_output;
      item.remote_valid   <= remote_valid;
      item.remote_value   <= remote_value;
    end
  end

  rttc_step u_step (
    .cfg        (cfg),
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .result     (result_next)
  );

  // Poll state, updated as each result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      state.relay_state    <= 1'b0;
      state.reported_state <= 1'b0;
      state.first_pending  <= 1'b1;
      state.toggle_prev    <= 1'b0;
      state.clear_prev     <= 1'b0;
      state.motion_prev    <= 1'b0;
      state.panic_prev     <= 1'b0;
      state.motion_running <= 1'b0;
      state.auto_off_start <= '0;
      state.motion_start   <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      relay_on       <= result_next.relay_on;
      report_written <= result_next.report_written;
    end
  end

endmodule

[rtl/core/rttc_step.sv]
module rttc_step
  import rttc_pkg::*;
(
  input  rttc_cfg_t    cfg,
  input  rttc_item_t   item,
  input  rttc_state_t  state,
  output rttc_state_t  state_next,
  output rttc_result_t result
);

  logic                 rel;
  logic                 rep;
  logic                 hw_driven;
  logic                 published;
  logic                 running;
  logic [TimeWidth-1:0] mot_start;
  logic [TimeWidth-1:0] ao_start;
  logic [TimeWidth-1:0] mot_elapsed;
  logic [TimeWidth-1:0] ao_elapsed;

  // One poll, steps applied in priority order
  always_comb begin
    rep       = item.remote_valid ? item.remote_value : state.reported_state;
    rel       = state.relay_state;
    hw_driven = 1'b0;
    published = 1'b0;
    running   = state.motion_running;
    mot_start = state.motion_start;
    ao_start  = state.auto_off_start;

    // panic edge forces on
    if (item.panic_level && !state.panic_prev) begin
      rel       = 1'b1;
      rep       = 1'b1;
      hw_driven = 1'b1;
      published = 1'b1;
    end

    // motion period start and expiry; frozen while disabled
    if (cfg.motion_enable) begin
      if (item.motion_level && !state.motion_prev) begin
        running   = 1'b1;
        rel       = 1'b1;
        rep       = 1'b1;
        hw_driven = 1'b1;
        published = 1'b1;
        mot_start = item.now_sec;
      end
    end
    mot_elapsed = item.now_sec - mot_start;
    if (cfg.motion_enable && running && (mot_elapsed >= cfg.motion_seconds)) begin
      rel       = 1'b0;
      rep       = 1'b0;
      hw_driven = 1'b1;
      published = 1'b1;
      running   = 1'b0;
    end

    // clear edge forces off
    if (item.clear_level && !state.clear_prev) begin
      rel       = 1'b0;
      rep       = 1'b0;
      hw_driven = 1'b1;
      published = 1'b1;
    end

    // first poll loads the hardware readback unless already driven
    if (state.first_pending) begin
      if (!hw_driven) begin
        rel = item.initial_output;
      end
      rep       = rel;
      published = 1'b1;
    end

    // toggle edge inverts and restarts the auto-off timer
    if (item.toggle_level && !state.toggle_prev) begin
      rel       = ~rel;
      rep       = rel;
      published = 1'b1;
      ao_start  = item.now_sec;
    end

    // remote value takes over
    if (rep != rel) begin
      rel      = rep;
      ao_start = item.now_sec;
    end

    // auto-off expiry
    ao_elapsed = item.now_sec - ao_start;
    if (rel && cfg.auto_off_enable && (ao_elapsed >= cfg.auto_off_seconds)) begin
      rel       = 1'b0;
      rep       = 1'b0;
      published = 1'b1;
    end

    state_next.relay_state    = rel;
    state_next.reported_state = rep;
    state_next.first_pending  = 1'b0;
    state_next.toggle_prev    = item.toggle_level;
    state_next.clear_prev     = item.clear_level;
    state_next.motion_prev    = item.motion_level;
    state_next.panic_prev     = item.panic_level;
    state_next.motion_running = running;
    state_next.auto_off_start = ao_start;
    state_next.motion_start   = mot_start;

    result.relay_on       = rel;
    result.report_written = published;
  end

endmodule
